@@ sv/midi_track_event_parser_top_assert.svh @@
// Assertion macros used by the parser core (mtep_core).
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define MTEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// Types shared by the MIDI track event parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } mtep_in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  status;
    logic [3:0]  channel;
    logic [31:0] tick;
    logic [7:0]  meta_kind;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic [7:0]  byte_d;
    logic [23:0] wide_value;
    logic        payload_last;
  } mtep_res_t;

endpackage

`default_nettype wire

@@ sv/mtep_in_if.sv @@
// ----------------------------------------------------------------------------
// mtep_in_if
// Input channel: one raw track byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;

  modport source (output valid, output data_byte, output track_start, input ready);
  modport sink (input valid, input data_byte, input track_start, output ready);
endinterface

`default_nettype wire

@@ sv/mtep_out_if.sv @@
// ----------------------------------------------------------------------------
// mtep_out_if
// Output channel: event records and payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  status;
  logic [3:0]  channel;
  logic [31:0] tick;
  logic [7:0]  meta_kind;
  logic [7:0]  byte_a;
  logic [7:0]  byte_b;
  logic [7:0]  byte_c;
  logic [7:0]  byte_d;
  logic [23:0] wide_value;
  logic        payload_last;

  modport source (
    output valid, output kind, output status, output channel, output tick,
    output meta_kind, output byte_a, output byte_b, output byte_c, output byte_d,
    output wide_value, output payload_last, input ready
  );
  modport sink (
    input valid, input kind, input status, input channel, input tick,
    input meta_kind, input byte_a, input byte_b, input byte_c, input byte_d,
    input wide_value, input payload_last, output ready
  );
endinterface

`default_nettype wire

@@ sv/midi_track_event_parser_top.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser_top
// Standard MIDI file track event parser, one track byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one track byte per item with track_start set on the first
//   byte of each track; that byte clears the tick, running status and parse
//   state before it is decoded.
//   out_o carries event records (kind 0) once a header is complete, and
//   sysex or text payload bytes (kind 1) with payload_last on the final one.
//   Most bytes (delta times, skipped meta data) produce no item.
//   Path: an accepted byte waits in the input register, is decoded when the
//   result register can load, and its result is registered there for out_o.
//   Throughput: one byte per cycle while out_o is not stalled; the parse
//   state updates in a single pass.
//   Stall: while out_o.ready is low and a result is held, the held input
//   byte waits and in_i.ready drops once the input register is full.
//   Reset: rst_ni clears both registers' valid flags and all parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_event_parser_top
  import mtep_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mtep_in_if.sink    in_i,
  mtep_out_if.source out_o
);

  logic          take;
  logic          free;
  logic          emit;
  mtep_in_item_t item;
  mtep_res_t     res;

  mtep_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .free_i (free),
    .take_o (take),
    .item_o (item)
  );

  mtep_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (item),
    .emit_o (emit),
    .res_o  (res)
  );

  mtep_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .emit_i (emit),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

@@ sv/mtep_in_stage.sv @@
// ----------------------------------------------------------------------------
// mtep_in_stage
// Input register: holds one byte item until the parser core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_in_stage
  import mtep_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mtep_in_if.sink    in_i,
  input  wire logic  free_i,
  output logic       take_o,
  output mtep_in_item_t item_o
);

  logic          valid_q, valid_d;
  mtep_in_item_t item_q;

  // Core takes the held item whenever the result register can load.
  assign take_o     = valid_q && free_i;
  assign in_i.ready = !valid_q || take_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.data_byte   <= in_i.data_byte;
      item_q.track_start <= in_i.track_start;
    end
  end

endmodule

`default_nettype wire

@@ sv/mtep_core.sv @@
// ----------------------------------------------------------------------------
// mtep_core
// Parse state and single-pass decode of one track byte per taken item.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_core
  import mtep_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire mtep_in_item_t item_i,
  output logic               emit_o,
  output mtep_res_t          res_o
);

  `include "midi_track_event_parser_top_assert.svh"

  localparam logic [3:0] PH_DELTA    = 4'd0;
  localparam logic [3:0] PH_STATUS   = 4'd1;
  localparam logic [3:0] PH_DATA1    = 4'd2;
  localparam logic [3:0] PH_DATA2    = 4'd3;
  localparam logic [3:0] PH_SYSLEN   = 4'd4;
  localparam logic [3:0] PH_METATYPE = 4'd5;
  localparam logic [3:0] PH_METALEN  = 4'd6;
  localparam logic [3:0] PH_FIXED    = 4'd7;
  localparam logic [3:0] PH_PAYLOAD  = 4'd8;
  localparam logic [3:0] PH_SKIP     = 4'd9;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_SEQNUM = 8'h00;
  localparam logic [7:0] META_CHPFX  = 8'h20;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_TIMSIG = 8'h58;
  localparam logic [7:0] META_KEYSIG = 8'h59;
  localparam logic [7:0] META_SEQSPC = 8'h7F;

  function automatic logic [2:0] fixed_len(input logic [7:0] m);
    logic [2:0] len;
    case (m)
      META_SEQNUM: len = 3'd3;
      META_CHPFX:  len = 3'd2;
      META_EOT:    len = 3'd1;
      META_TEMPO:  len = 3'd4;
      META_TIMSIG: len = 3'd5;
      META_KEYSIG: len = 3'd3;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_text(input logic [7:0] m);
    return ((m >= 8'h01) && (m <= 8'h07)) || (m == META_SEQSPC);
  endfunction

  function automatic logic one_data(input logic [7:0] st);
    return (st[7:4] == 4'hC) || (st[7:4] == 4'hD);
  endfunction

  logic [3:0]  phase_q, phase_d, phase_e;
  logic [31:0] tick_q, tick_d, tick_e;
  logic [27:0] vacc_q, vacc_d, vacc_e;
  logic [7:0]  run_q, run_d, run_e;
  logic [7:0]  cur_st_q, cur_st_d, cur_st_e;
  logic [7:0]  cur_meta_q, cur_meta_d, cur_meta_e;
  logic [27:0] left_q, left_d, left_e;
  logic [2:0]  bidx_q, bidx_d, bidx_e;
  logic [7:0]  cap_q [4];
  logic [7:0]  cap_d [4];
  logic [7:0]  cap_e [4];

  logic [7:0]  b;
  logic [27:0] acc_new;
  logic        vl_end;
  logic [27:0] left_dec;
  logic [2:0]  bidx_inc;
  logic [1:0]  cap_sel;
  logic        emit;
  mtep_res_t   res;
  logic [7:0]  rec_st;

  assign b        = item_i.data_byte;
  assign acc_new  = {vacc_e[20:0], b[6:0]};
  assign vl_end   = !b[7];
  assign left_dec = left_e - 28'd1;
  assign bidx_inc = bidx_e + 3'd1;
  assign cap_sel  = 2'(bidx_e - 3'd1);

  // Track start clears the state before the byte is decoded.
  always_comb begin
    if (item_i.track_start) begin
      phase_e    = PH_DELTA;
      tick_e     = '0;
      vacc_e     = '0;
      run_e      = '0;
      cur_st_e   = '0;
      cur_meta_e = '0;
      left_e     = '0;
      bidx_e     = '0;
      for (int i = 0; i < 4; i++) cap_e[i] = '0;
    end else begin
      phase_e    = phase_q;
      tick_e     = tick_q;
      vacc_e     = vacc_q;
      run_e      = run_q;
      cur_st_e   = cur_st_q;
      cur_meta_e = cur_meta_q;
      left_e     = left_q;
      bidx_e     = bidx_q;
      for (int i = 0; i < 4; i++) cap_e[i] = cap_q[i];
    end
  end

  always_comb begin
    phase_d    = phase_e;
    tick_d     = tick_e;
    vacc_d     = vacc_e;
    run_d      = run_e;
    cur_st_d   = cur_st_e;
    cur_meta_d = cur_meta_e;
    left_d     = left_e;
    bidx_d     = bidx_e;
    for (int i = 0; i < 4; i++) cap_d[i] = cap_e[i];
    emit           = 1'b0;
    rec_st         = cur_st_e;
    res            = '0;
    res.tick       = tick_e;

    case (phase_e)
      PH_DELTA: begin
        vacc_d = acc_new;
        if (vl_end) begin
          tick_d  = tick_e + {4'd0, acc_new};
          vacc_d  = '0;
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (run_e == 8'd0) begin
            // No running status: empty record, byte restarts a delta time.
            cur_st_d = '0;
            rec_st   = '0;
            emit     = 1'b1;
            tick_d   = tick_e + {25'd0, b[6:0]};
            vacc_d   = '0;
            phase_d  = PH_STATUS;
          end else begin
            cur_st_d   = run_e;
            cur_meta_d = '0;
            rec_st     = run_e;
            if (one_data(run_e)) begin
              emit       = 1'b1;
              res.byte_a = b;
              phase_d    = PH_DELTA;
            end else begin
              cap_d[0] = b;
              phase_d  = PH_DATA2;
            end
          end
        end else begin
          cur_st_d   = b;
          cur_meta_d = '0;
          rec_st     = b;
          if (b < ST_SYSEX) begin
            run_d   = b;
            phase_d = PH_DATA1;
          end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
            vacc_d  = '0;
            phase_d = PH_SYSLEN;
          end else if (b == ST_META) begin
            phase_d = PH_METATYPE;
          end else begin
            emit    = 1'b1;
            phase_d = PH_DELTA;
          end
        end
      end
      PH_DATA1: begin
        if (one_data(cur_st_e)) begin
          emit       = 1'b1;
          res.byte_a = b;
          phase_d    = PH_DELTA;
        end else begin
          cap_d[0] = b;
          phase_d  = PH_DATA2;
        end
      end
      PH_DATA2: begin
        emit       = 1'b1;
        res.byte_a = cap_e[0];
        res.byte_b = b;
        phase_d    = PH_DELTA;
      end
      PH_SYSLEN, PH_METALEN: begin
        vacc_d = acc_new;
        if (vl_end) begin
          left_d         = acc_new;
          vacc_d         = '0;
          emit           = 1'b1;
          res.meta_kind  = cur_meta_e;
          res.wide_value = (|acc_new[27:24]) ? 24'hFF_FFFF : acc_new[23:0];
          if (acc_new == 28'd0) begin
            phase_d = PH_DELTA;
          end else if (phase_e == PH_SYSLEN || is_text(cur_meta_e)) begin
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_METATYPE: begin
        cur_meta_d = b;
        if (fixed_len(b) == 3'd0) begin
          vacc_d  = '0;
          phase_d = PH_METALEN;
        end else begin
          bidx_d  = '0;
          phase_d = PH_FIXED;
        end
      end
      PH_FIXED: begin
        // Index zero is the length byte; data bytes land in cap[0..3].
        if (bidx_e >= 3'd1 && bidx_e <= 3'd4) begin
          cap_d[cap_sel] = b;
        end
        bidx_d = bidx_inc;
        if (bidx_inc >= fixed_len(cur_meta_e)) begin
          phase_d       = PH_DELTA;
          emit          = 1'b1;
          res.meta_kind = cur_meta_e;
          case (cur_meta_e)
            META_SEQNUM: res.wide_value = {8'd0, cap_d[0], cap_d[1]};
            META_TEMPO:  res.wide_value = {cap_d[0], cap_d[1], cap_d[2]};
            META_TIMSIG: begin
              res.byte_a = cap_d[0];
              res.byte_b = cap_d[1];
              res.byte_c = cap_d[2];
              res.byte_d = cap_d[3];
            end
            META_KEYSIG: begin
              res.byte_a = cap_d[0];
              res.byte_b = cap_d[1];
            end
            default: ;
          endcase
        end
      end
      PH_PAYLOAD: begin
        left_d            = left_dec;
        emit              = 1'b1;
        res.kind          = 1'b1;
        res.meta_kind     = cur_meta_e;
        res.byte_a        = b;
        res.payload_last  = (left_dec == 28'd0);
        if (left_dec == 28'd0) begin
          phase_d = PH_DELTA;
        end
      end
      PH_SKIP: begin
        left_d = left_dec;
        if (left_dec == 28'd0) begin
          phase_d = PH_DELTA;
        end
      end
      default: begin
        // Unused phase code: treat the byte as a fresh delta time.
        vacc_d  = {21'd0, b[6:0]};
        phase_d = PH_DELTA;
        if (vl_end) begin
          tick_d  = tick_e + {25'd0, b[6:0]};
          vacc_d  = '0;
          phase_d = PH_STATUS;
        end
      end
    endcase

    res.status  = (rec_st >= 8'h80 && rec_st < ST_SYSEX) ? {rec_st[7:4], 4'h0} : rec_st;
    res.channel = rec_st[3:0];
  end

  assign emit_o = take_i && emit;
  assign res_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DELTA;
      tick_q     <= '0;
      vacc_q     <= '0;
      run_q      <= '0;
      cur_st_q   <= '0;
      cur_meta_q <= '0;
      left_q     <= '0;
      bidx_q     <= '0;
      for (int i = 0; i < 4; i++) cap_q[i] <= '0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      vacc_q     <= vacc_d;
      run_q      <= run_d;
      cur_st_q   <= cur_st_d;
      cur_meta_q <= cur_meta_d;
      left_q     <= left_d;
      bidx_q     <= bidx_d;
      for (int i = 0; i < 4; i++) cap_q[i] <= cap_d[i];
    end
  end

  `MTEP_ASSERT_NOW(a_start_no_result, take_i && item_i.track_start, !emit_o,
                   "track start byte produced a result")
  `MTEP_ASSERT_NEXT(a_last_ends_event, emit_o && res_o.kind && res_o.payload_last,
                    phase_q == PH_DELTA, "last payload byte did not end the event")
  `MTEP_ASSERT_NOW(a_fixed_index, phase_q == PH_FIXED, bidx_q <= 3'd4,
                   "fixed meta byte index out of range")

endmodule

`default_nettype wire

@@ sv/mtep_out_stage.sv @@
// ----------------------------------------------------------------------------
// mtep_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_out_stage
  import mtep_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      take_i,
  input  wire logic      emit_i,
  input  wire mtep_res_t res_i,
  output logic           free_o,
  mtep_out_if.source     out_o
);

  logic      valid_q, valid_d;
  mtep_res_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = emit_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && emit_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.status       = res_q.status;
  assign out_o.channel      = res_q.channel;
  assign out_o.tick         = res_q.tick;
  assign out_o.meta_kind    = res_q.meta_kind;
  assign out_o.byte_a       = res_q.byte_a;
  assign out_o.byte_b       = res_q.byte_b;
  assign out_o.byte_c       = res_q.byte_c;
  assign out_o.byte_d       = res_q.byte_d;
  assign out_o.wide_value   = res_q.wide_value;
  assign out_o.payload_last = res_q.payload_last;

endmodule

`default_nettype wire
